// ----- rtl/aes128_block_cipher_top_assert.svh -----
// Assertion macros for the AES-128 block checker
`ifndef AES128_BLOCK_CIPHER_TOP_ASSERT_SVH
`define AES128_BLOCK_CIPHER_TOP_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define AES_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked on the next rising clock edge
`define AES_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/aes_pkg.sv -----
// ----------------------------------------------------------------------------
// AES package
// Shared types, constants and GF(2^8) byte functions.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int unsigned KEY_WORDS = 44;
    localparam int unsigned KEY_AW    = 6;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef logic [127:0] block_t;
    typedef logic [31:0]  word_t;

    // Control from the sequencer to the round unit
    typedef struct packed {
        logic decrypt;
        logic first;
        logic last;
    } round_ctrl_t;

    function automatic logic [7:0] gf_dbl(input logic [7:0] a);
        gf_dbl = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h00;
        p = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r = r ^ p;
            p = gf_dbl(p);
        end
        gf_mul = r;
    endfunction

    function automatic logic [7:0] gf_inv(input logic [7:0] a);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h01;
        p = a;
        for (int i = 0; i < 8; i++) begin
            if (i != 0) r = gf_mul(r, p);
            p = gf_mul(p, p);
        end
        gf_inv = r;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] v, input int unsigned n);
        rotl8 = (v << n) | (v >> (8 - n));
    endfunction

    function automatic logic [7:0] sbox_calc(input logic [7:0] v);
        logic [7:0] b;
        b = gf_inv(v);
        sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] inv_sbox_calc(input logic [7:0] v);
        inv_sbox_calc = gf_inv(rotl8(v, 1) ^ rotl8(v, 3) ^ rotl8(v, 6) ^ 8'h05);
    endfunction

    typedef logic [7:0] sbox_tab_t [256];

    function automatic sbox_tab_t build_sbox(input logic inverse);
        sbox_tab_t t;
        for (int i = 0; i < 256; i++)
            t[i] = inverse ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
        return t;
    endfunction

    localparam sbox_tab_t SBOX     = build_sbox(1'b0);
    localparam sbox_tab_t INV_SBOX = build_sbox(1'b1);

    function automatic word_t sub_word(input word_t w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = gf_dbl(a);
    endfunction

endpackage

// ----- rtl/aes128_block_cipher_top.sv -----
// AES-128 block cipher, one shared round unit under a small sequencer.
// Each block takes 11 steps: the sequencer fetches four round-key words through the
// registered key RAM read, then runs one round; a final output state loads the result.
// One block at a time: s_tready is low while a block is in flight.
// Key write: each write restarts re-expansion, one word a cycle; not ready meanwhile.
// Reset (synchronous, aresetn low): key clears to zero and expands again.
module aes128_block_cipher_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // block_low[63:0], block_high[127:64]
    input  logic         s_tuser,   // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // result_low[63:0], result_high[127:64]
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [63:0]  cfg_wdata
);
    import aes_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_ROUND, ST_OUT} state_t;

    state_t          state_reg;
    logic [127:0]    key_reg;
    logic            kx_start_reg;
    block_t          st_reg;
    logic            dec_reg;
    logic [3:0]      rnd_reg;      // round step 0..10
    logic [2:0]      fw_reg;       // key word fetch counter
    block_t          rk_reg;
    block_t          res_reg;
    logic            res_vld_reg;

    logic            kx_busy;
    logic            kx_we;
    logic [KEY_AW-1:0] kx_waddr;
    word_t           kx_wdata;
    logic [KEY_AW-1:0] raddr;
    word_t           rdata;
    logic [3:0]      key_round;
    round_ctrl_t     ctrl;
    block_t          st_next;

    aes_keyexp u_keyexp (
        .aclk(aclk), .aresetn(aresetn), .start(kx_start_reg), .key(key_reg),
        .busy(kx_busy), .we(kx_we), .waddr(kx_waddr), .wdata(kx_wdata)
    );

    aes_ram #(.WIDTH(32), .DEPTH(KEY_WORDS)) u_rk_ram (
        .aclk(aclk), .we(kx_we), .waddr(kx_waddr), .wdata(kx_wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // Decrypt walks the schedule from the top
    assign key_round = dec_reg ? (4'd10 - rnd_reg) : rnd_reg;
    assign raddr     = KEY_AW'({key_round, fw_reg[1:0]});

    assign ctrl.decrypt = dec_reg;
    assign ctrl.first   = (rnd_reg == 4'd0);
    assign ctrl.last    = (rnd_reg == 4'd10);

    aes_round u_round (.state_in(st_reg), .round_key(rk_reg), .ctrl(ctrl),
                       .state_out(st_next));

    // A waiting result sits in res_reg, so the input side need not wait for it
    assign s_tready = (state_reg == ST_IDLE) && !kx_busy && !kx_start_reg;
    assign m_tvalid = res_vld_reg;
    assign m_tdata  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            key_reg      <= '0;
            kx_start_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
            rnd_reg      <= '0;
            fw_reg       <= '0;
        end else begin
            kx_start_reg <= cfg_we;
            if (cfg_we) begin
                if (cfg_index) key_reg[127:64] <= cfg_wdata;
                else           key_reg[63:0]   <= cfg_wdata;
            end
            if (res_vld_reg && m_tready) res_vld_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        st_reg    <= s_tdata;
                        dec_reg   <= s_tuser;
                        rnd_reg   <= '0;
                        fw_reg    <= '0;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    // read data is registered, arriving in the cycle after its address; shift words in from the top
                    if (fw_reg != 3'd0) rk_reg <= {rdata, rk_reg[127:32]};
                    if (fw_reg == 3'd4) state_reg <= ST_ROUND;
                    fw_reg <= fw_reg + 3'd1;
                end
                ST_ROUND: begin
                    st_reg <= st_next;
                    fw_reg <= '0;
                    if (rnd_reg == 4'd10) state_reg <= ST_OUT;
                    else begin
                        rnd_reg   <= rnd_reg + 4'd1;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_OUT: begin
                    if (!res_vld_reg) begin
                        res_reg     <= st_reg;
                        res_vld_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/aes_ram.sv -----
// ----------------------------------------------------------------------------
// AES generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module aes_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 44
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem_reg[waddr] <= wdata;
        rdata <= mem_reg[raddr];
    end
endmodule

// ----- rtl/aes_round.sv -----
// ----------------------------------------------------------------------------
// AES round unit
// One forward or inverse cipher round, or the first key addition, on a 128-bit state, combinational.
// ----------------------------------------------------------------------------
module aes_round (
    input  aes_pkg::block_t      state_in,
    input  aes_pkg::block_t      round_key,
    input  aes_pkg::round_ctrl_t ctrl,
    output aes_pkg::block_t      state_out
);
    import aes_pkg::*;

    logic [7:0] s   [16];
    logic [7:0] t   [16];
    logic [7:0] k   [16];
    logic [7:0] m   [16];
    logic [7:0] x   [16];
    logic [7:0] a   [4];
    logic [7:0] a2  [4];
    logic [7:0] a4  [4];
    logic [7:0] a8  [4];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = state_in[8*i +: 8];
            k[i] = round_key[8*i +: 8];
        end
        // shift rows and substitute
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (ctrl.decrypt)
                    t[4*((c+r)%4)+r] = INV_SBOX[s[4*c+r]];
                else
                    t[4*c+r] = SBOX[s[4*((c+r)%4)+r]];
            end
        end
        // decrypt adds the key before the inverse mix
        for (int i = 0; i < 16; i++)
            x[i] = ctrl.decrypt ? (t[i] ^ k[i]) : t[i];
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                a[j]  = x[4*c+j];
                a2[j] = xt(a[j]);
                a4[j] = xt(a2[j]);
                a8[j] = xt(a4[j]);
            end
            for (int r = 0; r < 4; r++) begin
                if (ctrl.decrypt)
                    m[4*c+r] = (a8[r] ^ a4[r] ^ a2[r])
                             ^ (a8[(r+1)%4] ^ a2[(r+1)%4] ^ a[(r+1)%4])
                             ^ (a8[(r+2)%4] ^ a4[(r+2)%4] ^ a[(r+2)%4])
                             ^ (a8[(r+3)%4] ^ a[(r+3)%4]);
                else
                    m[4*c+r] = a2[r] ^ (a2[(r+1)%4] ^ a[(r+1)%4])
                             ^ a[(r+2)%4] ^ a[(r+3)%4];
            end
        end
        for (int i = 0; i < 16; i++) begin
            if (ctrl.first)
                state_out[8*i +: 8] = s[i] ^ k[i];
            else if (ctrl.decrypt)
                state_out[8*i +: 8] = ctrl.last ? x[i] : m[i];
            else
                state_out[8*i +: 8] = (ctrl.last ? x[i] : m[i]) ^ k[i];
        end
    end
endmodule

// ----- rtl/aes_keyexp.sv -----
// ----------------------------------------------------------------------------
// AES key expansion
// Expands the key one schedule word a cycle into the round-key RAM.
// ----------------------------------------------------------------------------
module aes_keyexp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [127:0]                key,
    output logic                        busy,
    output logic                        we,
    output logic [aes_pkg::KEY_AW-1:0]  waddr,
    output aes_pkg::word_t              wdata
);
    import aes_pkg::*;

    logic                busy_reg;
    logic [KEY_AW-1:0]   idx_reg;
    word_t               w_reg [4];
    logic [7:0]          rc_reg;
    word_t               t;
    word_t               nw;

    always_comb begin
        t  = w_reg[3];
        if (idx_reg[1:0] == 2'd0)
            t = sub_word({t[7:0], t[31:8]}) ^ {24'h0, rc_reg};
        nw = w_reg[0] ^ t;
    end

    assign busy  = busy_reg;
    assign we    = busy_reg;
    assign waddr = idx_reg;
    assign wdata = (idx_reg < KEY_AW'(4)) ? w_reg[idx_reg[1:0]] : nw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            rc_reg   <= 8'h01;
            for (int i = 0; i < 4; i++) w_reg[i] <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            rc_reg   <= 8'h01;
            for (int i = 0; i < 4; i++) w_reg[i] <= key[32*i +: 32];
        end else if (busy_reg) begin
            if (idx_reg >= KEY_AW'(4)) begin
                w_reg[0] <= w_reg[1];
                w_reg[1] <= w_reg[2];
                w_reg[2] <= w_reg[3];
                w_reg[3] <= nw;
                if (idx_reg[1:0] == 2'd0) rc_reg <= gf_dbl(rc_reg);
            end
            if (idx_reg == KEY_AW'(KEY_WORDS - 1)) busy_reg <= 1'b0;
            idx_reg <= idx_reg + KEY_AW'(1);
        end
    end
endmodule

// ----- rtl/aes128_block_cipher_checker.sv -----
// ----------------------------------------------------------------------------
// AES port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`include "aes128_block_cipher_top_assert.svh"
module aes128_block_cipher_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         cfg_we
);
    `AES_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "ready right after accept")
    `AES_ASSERT_NEXT(a_out_single, aclk, aresetn, m_tvalid && m_tready, !m_tvalid, "result repeated")
    `AES_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
    `AES_ASSERT_NEXT(a_cfg_blocks, aclk, aresetn, cfg_we, !s_tready, "ready during key expansion")
endmodule

bind aes128_block_cipher_top aes128_block_cipher_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .cfg_we(cfg_we)
);

// ----- sim/aes128_block_cipher_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-128 block cipher testbench
// Streams encrypt and decrypt words through the cipher under several keys,
// predicts each result with an independent AES-128 model and compares them
// in order, while both stream sides idle and stall at random for most of the run.
// ----------------------------------------------------------------------------
module aes128_block_cipher_top_tb;
    import aes_pkg::*;

    localparam int DRAIN_CYCLES = 80;     // settling wait after the queues have emptied
    localparam int STALL_LIMIT  = 20000;  // cycles with no handshake on either side and no key write

    typedef struct packed {
        logic         cmd;
        logic [127:0] blk;
    } cipher_word_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;   // block_low[63:0], block_high[127:64]
    logic         s_tuser = 1'b0; // command
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;        // result_low[63:0], result_high[127:64]
    logic         cfg_we = 1'b0;
    logic         cfg_index = 1'b0;
    logic [63:0]  cfg_wdata = '0;

    aes128_block_cipher_top uut (.*);

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------- cipher predictor ----------------
    logic [7:0]  sb_fwd [256];
    logic [7:0]  sb_inv [256];
    logic [31:0] sched [44];
    logic [63:0] key_lo_q = '0;
    logic [63:0] key_hi_q = '0;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = xtime(a);
        end
        return acc;
    endfunction

    // Fill both substitution tables; inverse taken as a^254
    task automatic build_tables();
        logic [7:0] x, p, y;
        for (int v = 0; v < 256; v++) begin
            x = 8'h01;
            p = v[7:0];
            for (int e = 0; e < 8; e++) begin
                if (e != 0) x = fmul(x, p);
                p = fmul(p, p);
            end
            y = x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]}
                ^ {x[3:0], x[7:4]} ^ 8'h63;
            sb_fwd[v] = y;
            sb_inv[y] = v[7:0];
        end
    endtask

    task automatic expand_schedule();
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        sched[0] = key_lo_q[31:0];
        sched[1] = key_lo_q[63:32];
        sched[2] = key_hi_q[31:0];
        sched[3] = key_hi_q[63:32];
        for (int i = 4; i < 44; i++) begin
            t = sched[i-1];
            if (i % 4 == 0) begin
                t = {sb_fwd[t[7:0]], sb_fwd[t[31:24]], sb_fwd[t[23:16]], sb_fwd[t[15:8]]};
                t[7:0] ^= rc;
                rc = xtime(rc);
            end
            sched[i] = sched[i-4] ^ t;
        end
    endtask

    function automatic logic [127:0] add_key(input logic [127:0] s, input int rnd);
        return s ^ {sched[4*rnd+3], sched[4*rnd+2], sched[4*rnd+1], sched[4*rnd]};
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
        logic [7:0]   m [4];
        logic [7:0]   o;
        logic [127:0] r;
        if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
        else     m = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++)
            for (int row = 0; row < 4; row++) begin
                o = 8'h00;
                for (int j = 0; j < 4; j++)
                    o ^= fmul(m[(j - row + 4) % 4], s[8*(4*c+j) +: 8]);
                r[8*(4*c+row) +: 8] = o;
            end
        return r;
    endfunction

    function automatic logic [127:0] cipher_result(input cipher_word_t w);
        logic [127:0] s, t;
        s = w.blk;
        if (w.cmd == CMD_DECRYPT) begin
            s = add_key(s, 10);
            for (int rnd = 9; rnd >= 0; rnd--) begin
                for (int c = 0; c < 4; c++)
                    for (int row = 0; row < 4; row++)
                        t[8*(4*((c+row)%4)+row) +: 8] = sb_inv[s[8*(4*c+row) +: 8]];
                s = add_key(t, rnd);
                if (rnd > 0) s = mix_cols(s, 1'b1);
            end
        end else begin
            s = add_key(s, 0);
            for (int rnd = 1; rnd <= 10; rnd++) begin
                for (int c = 0; c < 4; c++)
                    for (int row = 0; row < 4; row++)
                        t[8*(4*c+row) +: 8] = sb_fwd[s[8*(4*((c+row)%4)+row) +: 8]];
                s = (rnd != 10) ? mix_cols(t, 1'b0) : t;
                s = add_key(s, rnd);
            end
        end
        return s;
    endfunction

    // ---------------- stimulus queues and knobs ----------------
    cipher_word_t  pending_words [$];
    logic [127:0]  expected_results [$];
    int            send_idle_pct = 24;
    int            recv_idle_pct = 57;
    int            error_count = 0;
    int            quiet_cycles = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Driver: on acceptance, predict the result; then load the next word or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(cipher_result('{s_tuser, s_tdata}));
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cipher_word_t w;
                    w = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= w.cmd;
                    s_tdata  <= w.blk;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result_low", m_tdata[63:0], 64'h0);
                end else begin
                    logic [127:0] want;
                    want = expected_results.pop_front();
                    if (m_tdata[63:0] !== want[63:0])
                        report_mismatch("result_low", m_tdata[63:0], want[63:0]);
                    if (m_tdata[127:64] !== want[127:64])
                        report_mismatch("result_high", m_tdata[127:64], want[127:64]);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: give up when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[aes128_block_cipher_top] ERROR");
            $finish;
        end
    end

    // Wait until everything queued has come back, then let the block settle
    task automatic drain();
        while (pending_words.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Key writes happen only with the block idle; track the key in the predictor
    task automatic write_key(input logic [63:0] lo, input logic [63:0] hi);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= 1'b0;
        cfg_wdata <= lo;
        key_lo_q = lo;
        expand_schedule();
        @(posedge aclk);
        cfg_index <= 1'b1;
        cfg_wdata <= hi;
        key_hi_q = hi;
        expand_schedule();
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [127:0] rand_block();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Queue plain and cipher words, mostly random with a few one-hot and one-cold patterns
    task automatic queue_random(input int count);
        cipher_word_t w;
        for (int i = 0; i < count; i++) begin
            w.cmd = $urandom_range(1) ? CMD_DECRYPT : CMD_ENCRYPT;
            case ($urandom_range(9))
                0:       w.blk = 128'd1 << $urandom_range(127);
                1:       w.blk = ~(128'd1 << $urandom_range(127));
                default: w.blk = rand_block();
            endcase
            pending_words.push_back(w);
        end
    endtask

    initial begin
        logic [63:0] klo, khi;
        build_tables();
        key_lo_q = '0;
        key_hi_q = '0;
        expand_schedule();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: all-zero reset key, extreme blocks both ways
        pending_words.push_back('{CMD_ENCRYPT, 128'h0});
        pending_words.push_back('{CMD_DECRYPT, 128'h0});
        pending_words.push_back('{CMD_ENCRYPT, {128{1'b1}}});
        pending_words.push_back('{CMD_DECRYPT, {128{1'b1}}});
        pending_words.push_back('{CMD_ENCRYPT, {16{8'h55}}});
        pending_words.push_back('{CMD_DECRYPT, {16{8'haa}}});
        drain();

        // Directed: standard example key and plaintext, then more blocks both ways
        write_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
        pending_words.push_back('{CMD_ENCRYPT, {64'hffeeddccbbaa9988, 64'h7766554433221100}});
        pending_words.push_back('{CMD_DECRYPT, {64'h5ac5b47080b7cdd8, 64'h30d8cd6ad8e0c469}});
        pending_words.push_back('{CMD_ENCRYPT, 128'h0});
        pending_words.push_back('{CMD_DECRYPT, {128{1'b1}}});
        drain();

        // Directed: all-ones key
        write_key({64{1'b1}}, {64{1'b1}});
        pending_words.push_back('{CMD_ENCRYPT, 128'h0});
        pending_words.push_back('{CMD_DECRYPT, 128'h0});
        pending_words.push_back('{CMD_ENCRYPT, {128{1'b1}}});
        pending_words.push_back('{CMD_DECRYPT, {128{1'b1}}});
        queue_random(4);
        drain();

        // Random part: new key per segment, idle pattern changes across the run
        for (int seg = 0; seg < 9; seg++) begin
            if (seg == 3) begin
                send_idle_pct = 57;
                recv_idle_pct = 24;
            end else if (seg == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (seg % 3)
                0: begin klo = {$urandom, $urandom}; khi = {$urandom, $urandom}; end
                1: begin klo = '0; khi = {$urandom, $urandom}; end
                default: begin klo = {$urandom, $urandom}; khi = {64{1'b1}}; end
            endcase
            write_key(klo, khi);
            queue_random(178);
            drain();
        end

        if (error_count == 0)
            $display("[aes128_block_cipher_top] OK");
        else
            $display("[aes128_block_cipher_top] ERROR");
        $finish;
    end

endmodule
